// ===== rtl/wgm_pkg.sv =====
package wgm_pkg;

   localparam int PATTERN_DEPTH_DEF = 64;
   localparam int SUBJECT_DEPTH_DEF = 64;

   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_PATTERN  = 2'd1;
   localparam logic [1:0] OP_SUBJECT  = 2'd2;
   localparam logic [1:0] OP_EVALUATE = 2'd3;

   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] ANY_BYTE  = 8'h3F;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic matched;
      logic fault;
   } rsp_type;

endpackage

// ===== rtl/wildcard_glob_matcher.sv =====
// Append and clear requests: accepted while idle, no response.
// Evaluate: one matcher step per cycle through the synchronous pattern/subject
// store reads; at most (S+1)*(P+1) steps.
// Input is stalled while an evaluate runs or its response waits to be loaded.
// Synchronous active-high reset clears counts, fault flag and control; stores
// keep stale data, only entries below the counts are ever used.
module wildcard_glob_matcher #(
   parameter int PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH_DEF,
   parameter int SUBJECT_DEPTH = wgm_pkg::SUBJECT_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wgm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wgm_pkg::rsp_type rsp_data
);

   localparam int PCW = $clog2(PATTERN_DEPTH + 1);
   localparam int SCW = $clog2(SUBJECT_DEPTH + 1);
   localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;
   localparam logic [PCW-1:0] PAT_FULL = PCW'(PATTERN_DEPTH);
   localparam logic [SCW-1:0] SUB_FULL = SCW'(SUBJECT_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_TAIL = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [7:0] pat_mem [PATTERN_DEPTH];
   logic [7:0] sub_mem [SUBJECT_DEPTH];
   logic [7:0] pat_rd_ff, sub_rd_ff;

   logic [1:0]     state_ff, state_in;
   logic [PCW-1:0] pat_count_ff, pat_count_in;
   logic [SCW-1:0] sub_count_ff, sub_count_in;
   logic           fault_ff, fault_in;
   logic [PCW-1:0] p_ff, p_in, bp_ff, bp_in;
   logic [SCW-1:0] s_ff, s_in, bs_ff, bs_in;
   logic           star_ff, star_in;
   wgm_pkg::rsp_type result_ff, result_in;
   logic           rsp_valid_ff, rsp_valid_in;
   wgm_pkg::rsp_type rsp_ff, rsp_in;

   logic accept, pat_we, sub_we, p_live;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign p_live    = (p_ff < pat_count_ff);

   assign pat_we = accept && (req_data.opcode == wgm_pkg::OP_PATTERN) &&
                   (req_data.symbol != 8'd0) && (pat_count_ff != PAT_FULL);
   assign sub_we = accept && (req_data.opcode == wgm_pkg::OP_SUBJECT) &&
                   (req_data.symbol != 8'd0) && (sub_count_ff != SUB_FULL);

   always_comb begin
      state_in     = state_ff;
      pat_count_in = pat_count_ff;
      sub_count_in = sub_count_ff;
      fault_in     = fault_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      bp_in        = bp_ff;
      bs_in        = bs_ff;
      star_in      = star_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  wgm_pkg::OP_CLEAR: begin
                     pat_count_in = '0;
                     sub_count_in = '0;
                     fault_in     = 1'b0;
                  end
                  wgm_pkg::OP_PATTERN: begin
                     if (pat_we) pat_count_in = pat_count_ff + PCW'(1);
                     else fault_in = 1'b1;
                  end
                  wgm_pkg::OP_SUBJECT: begin
                     if (sub_we) sub_count_in = sub_count_ff + SCW'(1);
                     else fault_in = 1'b1;
                  end
                  default: begin
                     p_in    = '0;
                     s_in    = '0;
                     bp_in   = '0;
                     bs_in   = '0;
                     star_in = 1'b0;
                     if (fault_ff) begin
                        result_in = '{matched: 1'b0, fault: 1'b1};
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_RUN;
                     end
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (s_ff >= sub_count_ff) begin
               state_in = ST_TAIL;
            end else if (p_live && pat_rd_ff == wgm_pkg::STAR_BYTE) begin
               p_in = p_ff + PCW'(1);
               if (p_in == pat_count_ff) begin
                  result_in = '{matched: 1'b1, fault: 1'b0};
                  state_in  = ST_DONE;
               end else begin
                  star_in = 1'b1;
                  bp_in   = p_in;
                  bs_in   = s_ff + SCW'(1);
               end
            end else if (p_live && (pat_rd_ff == sub_rd_ff ||
                                    pat_rd_ff == wgm_pkg::ANY_BYTE)) begin
               p_in = p_ff + PCW'(1);
               s_in = s_ff + SCW'(1);
            end else if (star_ff) begin
               p_in  = bp_ff;
               s_in  = bs_ff;
               bs_in = bs_ff + SCW'(1);
            end else begin
               result_in = '{matched: 1'b0, fault: 1'b0};
               state_in  = ST_DONE;
            end
         end
         ST_TAIL: begin
            if (p_live && pat_rd_ff == wgm_pkg::STAR_BYTE) begin
               p_in = p_ff + PCW'(1);
            end else begin
               result_in = '{matched: (p_ff == pat_count_ff), fault: 1'b0};
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pat_we) pat_mem[pat_count_ff[PAW-1:0]] <= req_data.symbol;
      pat_rd_ff <= pat_mem[p_in[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sub_we) sub_mem[sub_count_ff[SAW-1:0]] <= req_data.symbol;
      sub_rd_ff <= sub_mem[s_in[SAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pat_count_ff <= '0;
         sub_count_ff <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p_ff         <= '0;
         s_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         pat_count_ff <= pat_count_in;
         sub_count_ff <= sub_count_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         s_ff         <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      bp_ff     <= bp_in;
      bs_ff     <= bs_in;
      star_ff   <= star_in;
      result_ff <= result_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTHESIS
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (pat_count_ff <= PAT_FULL) && (sub_count_ff <= SUB_FULL))
      else $error("store count beyond depth");

   a_stores_stable_in_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN || state_ff == ST_TAIL) |=>
         $stable(pat_count_ff) && $stable(sub_count_ff))
      else $error("store count changed during evaluate");

   a_fault_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.matched && rsp_ff.fault))
      else $error("response flags both match and fault");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN || state_ff == ST_TAIL) |->
         (p_ff <= pat_count_ff) && (s_ff <= sub_count_ff))
      else $error("walk index past store count");
`endif

endmodule

// ===== bench/wildcard_glob_matcher_tb.sv =====
`timescale 1ns / 100ps

module wildcard_glob_matcher_tb;

   localparam int PDEPTH = wgm_pkg::PATTERN_DEPTH_DEF;
   localparam int SDEPTH = wgm_pkg::SUBJECT_DEPTH_DEF;
   localparam int TOTAL_ITEMS = 800;
   localparam int HOLD_CYCLES = 400;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   wgm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   wgm_pkg::rsp_type rsp_data;

   wildcard_glob_matcher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   wgm_pkg::req_type requests_to_send[$];
   wgm_pkg::rsp_type verdicts_due[$];
   logic [7:0] pattern_mem [PDEPTH];
   logic [7:0] subject_mem [SDEPTH];
   int         pattern_len = 0;
   int         subject_len = 0;
   bit         fault_seen = 1'b0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   bit         hold_on = 1'b0;
   bit         req_taken = 1'b0;
   int         accepted = 0;
   int         sent = 0;
   int         mismatches = 0;

   function automatic bit glob_matches();
      int p = 0;
      int s = 0;
      int back_p = 0;
      int back_s = 0;
      bit have_star = 1'b0;
      while (s < subject_len) begin
         if (p < pattern_len && pattern_mem[p] == wgm_pkg::STAR_BYTE) begin
            p++;
            if (p == pattern_len) return 1'b1;
            have_star = 1'b1;
            back_p = p;
            back_s = s + 1;
         end else if (p < pattern_len &&
                      (pattern_mem[p] == subject_mem[s] ||
                       pattern_mem[p] == wgm_pkg::ANY_BYTE)) begin
            p++;
            s++;
         end else if (have_star) begin
            p = back_p;
            s = back_s;
            back_s++;
         end else begin
            return 1'b0;
         end
      end
      while (p < pattern_len && pattern_mem[p] == wgm_pkg::STAR_BYTE) p++;
      return p == pattern_len;
   endfunction

   task automatic apply_request(input wgm_pkg::req_type r);
      wgm_pkg::rsp_type v;
      case (r.opcode)
         wgm_pkg::OP_CLEAR: begin
            pattern_len = 0;
            subject_len = 0;
            fault_seen = 1'b0;
         end
         wgm_pkg::OP_PATTERN: begin
            if (r.symbol == 8'h00 || pattern_len >= PDEPTH) begin
               fault_seen = 1'b1;
            end else begin
               pattern_mem[pattern_len] = r.symbol;
               pattern_len++;
            end
         end
         wgm_pkg::OP_SUBJECT: begin
            if (r.symbol == 8'h00 || subject_len >= SDEPTH) begin
               fault_seen = 1'b1;
            end else begin
               subject_mem[subject_len] = r.symbol;
               subject_len++;
            end
         end
         default: begin
            v.fault = fault_seen;
            v.matched = fault_seen ? 1'b0 : glob_matches();
            verdicts_due.push_back(v);
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      wgm_pkg::rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: matched=%0b fault=%0b",
                           rsp_data.matched, rsp_data.fault);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_data.matched !== want.matched || rsp_data.fault !== want.fault) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected matched=%0b fault=%0b, got %0b %0b",
                              want.matched, want.fault, rsp_data.matched, rsp_data.fault);
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_data);
            accepted++;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= requests_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= !reset && !hold_on && ($urandom_range(99) >= rsp_stall_pct);

   // long response back-pressure while requests keep coming
   initial begin
      wait (accepted >= 60);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   function automatic void send(input logic [1:0] op, input logic [7:0] sym);
      wgm_pkg::req_type r;
      r.opcode = op;
      r.symbol = sym;
      requests_to_send.push_back(r);
      sent++;
   endfunction

   function automatic void send_text(input logic [1:0] op, input string txt);
      for (int i = 0; i < txt.len(); i++) send(op, txt[i]);
   endfunction

   function automatic logic [7:0] pick_symbol(input bit wide);
      if (wide) begin
         if ($urandom_range(49) == 0) return 8'h00;
         return 8'($urandom_range(255, 1));
      end
      case ($urandom_range(5))
         0: return "a";
         1: return "b";
         2: return "c";
         3: return "A";
         4: return wgm_pkg::STAR_BYTE;
         default: return wgm_pkg::ANY_BYTE;
      endcase
   endfunction

   task automatic queue_scenario();
      logic [7:0] pat[$];
      logic [7:0] subj[$];
      int plen;
      bit wide;
      bit subject_first;
      wide = ($urandom_range(3) == 0);
      subject_first = ($urandom_range(3) == 0);
      plen = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(10);
      for (int i = 0; i < plen; i++) pat.push_back(pick_symbol(wide));
      if ($urandom_range(4) < 3) begin
         foreach (pat[i]) begin
            if (pat[i] == wgm_pkg::STAR_BYTE)
               repeat ($urandom_range(3)) subj.push_back(pick_symbol(wide));
            else if (pat[i] == wgm_pkg::ANY_BYTE)
               subj.push_back(pick_symbol(wide));
            else
               subj.push_back(pat[i]);
         end
         if (subj.size() != 0 && $urandom_range(2) == 0)
            subj[$urandom_range(subj.size() - 1)] = pick_symbol(wide);
      end else begin
         repeat ((plen > 40) ? $urandom_range(70, 55) : $urandom_range(12))
            subj.push_back(pick_symbol(wide));
      end
      while (subj.size() > 70) void'(subj.pop_back());

      send(wgm_pkg::OP_CLEAR, 8'($urandom));
      if (subject_first) foreach (subj[i]) send(wgm_pkg::OP_SUBJECT, subj[i]);
      foreach (pat[i]) send(wgm_pkg::OP_PATTERN, pat[i]);
      if (!subject_first) foreach (subj[i]) send(wgm_pkg::OP_SUBJECT, subj[i]);
      send(wgm_pkg::OP_EVALUATE, 8'($urandom));
      if ($urandom_range(3) == 0) begin
         send($urandom_range(1) ? wgm_pkg::OP_PATTERN : wgm_pkg::OP_SUBJECT,
              pick_symbol(wide));
         send(wgm_pkg::OP_EVALUATE, 8'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty stores, star-only, '?', case, zero byte, byte extremes
      send(wgm_pkg::OP_EVALUATE, 8'h00);
      send(wgm_pkg::OP_PATTERN, wgm_pkg::STAR_BYTE);
      send(wgm_pkg::OP_EVALUATE, 8'hFF);
      send_text(wgm_pkg::OP_SUBJECT, "ab");
      send(wgm_pkg::OP_EVALUATE, 8'h55);
      send(wgm_pkg::OP_CLEAR, 8'hAA);
      send_text(wgm_pkg::OP_PATTERN, "a?C");
      send_text(wgm_pkg::OP_SUBJECT, "axC");
      send(wgm_pkg::OP_EVALUATE, 8'h00);
      send(wgm_pkg::OP_CLEAR, 8'hFF);
      send_text(wgm_pkg::OP_PATTERN, "A");
      send_text(wgm_pkg::OP_SUBJECT, "a");
      send(wgm_pkg::OP_EVALUATE, 8'h00);
      send(wgm_pkg::OP_CLEAR, 8'h00);
      send(wgm_pkg::OP_PATTERN, 8'h00);
      send(wgm_pkg::OP_EVALUATE, 8'h00);
      send(wgm_pkg::OP_CLEAR, 8'h00);
      send(wgm_pkg::OP_PATTERN, 8'hFF);
      send(wgm_pkg::OP_SUBJECT, 8'hFF);
      send(wgm_pkg::OP_EVALUATE, 8'h00);
      wait (requests_to_send.size() == 0 && !req_valid && verdicts_due.size() == 0);

      for (int phase = 0; phase < 4; phase++) begin
         @(posedge clock);
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 49; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 49; end
            default: begin send_idle_pct = 19; rsp_stall_pct = 19; end
         endcase
         while (sent < (phase + 1) * TOTAL_ITEMS / 4) begin
            if ($urandom_range(9) == 0)
               repeat ($urandom_range(5, 1)) send(2'($urandom_range(3)), 8'($urandom));
            else
               queue_scenario();
         end
         // sender waits for every outstanding verdict
         wait (requests_to_send.size() == 0 && !req_valid && verdicts_due.size() == 0);
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0 && verdicts_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wgm_pkg.sv
rtl/wildcard_glob_matcher.sv
bench/wildcard_glob_matcher_tb.sv
